// ===== src/cobs_dfr_pkg.sv =====
// Shared types, status codes and the CRC-16 byte update for the COBS deframer.
// No dependencies; used by cobs_dfr_ctrl, cobs_dfr_dp and the top level.
`default_nettype none

package cobs_dfr_pkg;

  localparam int CAPACITY = 256;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;
  localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;
  localparam logic [7:0]  CODE_FULL = 8'hFF;

  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_OVF    = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_MALF   = 3'd3;
  localparam logic [2:0] ST_CRCERR = 3'd4;
  localparam logic [2:0] ST_GOOD   = 3'd5;
  localparam logic [2:0] ST_READ   = 3'd6;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  frame_length;
    logic [7:0]  read_data;
    logic [15:0] malformed_count;
    logic [15:0] crc_error_count;
  } out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_READ,
    OP_CODE,
    OP_BLK,
    OP_DATA,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic is_read;
    logic decode_needed;
    logic code_bad;
    logic remain_nz;
    logic zero_need;
    logic more;
  } dp_st_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/cobs_dfr_ctrl.sv =====
// Controller state machine for the COBS deframer: handshakes and datapath commands.
// Depends on cobs_dfr_pkg.
`default_nettype none

module cobs_dfr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire cobs_dfr_pkg::dp_st_t st,
  output cobs_dfr_pkg::dp_op_t      op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CODE,
    S_BLK,
    S_DATA,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   res_load;

  assign in_stall  = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    op        = cobs_dfr_pkg::OP_NONE;
    state_nxt = state_r;
    res_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op = cobs_dfr_pkg::OP_ACCEPT;
          if (st.is_read) begin
            state_nxt = S_RD;
          end else if (st.decode_needed) begin
            state_nxt = S_BLK;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      S_RD: begin
        op        = cobs_dfr_pkg::OP_READ;
        res_load  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CODE: begin
        op = cobs_dfr_pkg::OP_CODE;
        if (st.code_bad) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_BLK;
        end
      end
      S_BLK: begin
        op = cobs_dfr_pkg::OP_BLK;
        if (st.remain_nz) begin
          state_nxt = S_DATA;
        end else if (st.zero_need) begin
          state_nxt = S_BLK;
        end else if (st.more) begin
          state_nxt = S_CODE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DATA: begin
        op        = cobs_dfr_pkg::OP_DATA;
        state_nxt = S_BLK;
      end
      S_FIN: begin
        op        = cobs_dfr_pkg::OP_FIN;
        res_load  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/cobs_dfr_dp.sv =====
// Datapath for the COBS deframer: frame store, in-place decode walk, CRC, counters.
// Depends on cobs_dfr_pkg; driven by cobs_dfr_ctrl.
`default_nettype none

module cobs_dfr_dp #(
  parameter int CAPACITY = cobs_dfr_pkg::CAPACITY
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cobs_dfr_pkg::dp_op_t op,
  input  wire cobs_dfr_pkg::in_t    in_data,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_data,
  output cobs_dfr_pkg::dp_st_t      st,
  output cobs_dfr_pkg::out_t        out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = ((CW > 8) ? CW : 8) + 1;

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rdata_r;
  logic [CW-1:0] fill_r;
  logic          ovf_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] src_r;
  logic [CW-1:0] dst_r;
  logic [7:0]    remain_r;
  logic          code_ff_r;
  logic [15:0]   crc_r;
  logic [7:0]    h0_r;
  logic [7:0]    h1_r;
  logic          rd_ok_r;
  logic [7:0]    good_len_r;
  logic [7:0]    good_len_nxt;
  logic [15:0]   mal_r;
  logic [15:0]   mal_nxt;
  logic [15:0]   crce_r;
  logic [15:0]   crce_nxt;
  logic [15:0]   crc_init_r;
  cobs_dfr_pkg::out_t out_r;

  logic          is_delim;
  logic          is_data;
  logic          has_room;
  logic          rd_ok;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  logic [AW-1:0] ra;
  logic          res_load;
  logic [2:0]    res_status;

  assign is_delim = !in_data.kind && (in_data.byte_in == 8'h00);
  assign is_data  = !in_data.kind && (in_data.byte_in != 8'h00);
  assign has_room = fill_r < CW'(CAPACITY);
  assign rd_ok    = SW'(in_data.read_index) < SW'(CAPACITY);

  assign st.is_read       = in_data.kind;
  assign st.decode_needed = is_delim && (fill_r != '0) && !ovf_r;
  assign st.code_bad      = (SW'(src_r) + SW'(rdata_r)) > SW'(n_r);
  assign st.more          = src_r < n_r;
  assign st.remain_nz     = remain_r != 8'h00;
  assign st.zero_need     = (remain_r == 8'h00) && !code_ff_r && st.more;

  assign emit      = (op == cobs_dfr_pkg::OP_DATA) ||
                     ((op == cobs_dfr_pkg::OP_BLK) && st.zero_need);
  assign emit_byte = (op == cobs_dfr_pkg::OP_DATA) ? rdata_r : 8'h00;

  always_comb begin
    if (op == cobs_dfr_pkg::OP_ACCEPT) begin
      we = is_data && has_room;
      wa = fill_r[AW-1:0];
      wd = in_data.byte_in;
      ra = AW'(in_data.read_index);
    end else begin
      we = emit;
      wa = dst_r[AW-1:0];
      wd = emit_byte;
      ra = src_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  always_comb begin
    res_load     = 1'b0;
    res_status   = cobs_dfr_pkg::ST_STORED;
    mal_nxt      = mal_r;
    crce_nxt     = crce_r;
    good_len_nxt = good_len_r;
    case (op)
      cobs_dfr_pkg::OP_ACCEPT: begin
        if (is_data) begin
          res_load   = 1'b1;
          res_status = has_room ? cobs_dfr_pkg::ST_STORED : cobs_dfr_pkg::ST_OVF;
        end else if (is_delim) begin
          if (fill_r == '0) begin
            res_load   = 1'b1;
            res_status = cobs_dfr_pkg::ST_EMPTY;
          end else if (ovf_r) begin
            res_load   = 1'b1;
            res_status = cobs_dfr_pkg::ST_MALF;
            mal_nxt    = mal_r + 16'd1;
          end
        end
      end
      cobs_dfr_pkg::OP_READ: begin
        res_load   = 1'b1;
        res_status = cobs_dfr_pkg::ST_READ;
      end
      cobs_dfr_pkg::OP_CODE: begin
        if (st.code_bad) begin
          res_load   = 1'b1;
          res_status = cobs_dfr_pkg::ST_MALF;
          mal_nxt    = mal_r + 16'd1;
        end
      end
      cobs_dfr_pkg::OP_FIN: begin
        res_load = 1'b1;
        if (dst_r < CW'(3)) begin
          res_status = cobs_dfr_pkg::ST_MALF;
          mal_nxt    = mal_r + 16'd1;
        end else if (crc_r != {h0_r, h1_r}) begin
          res_status = cobs_dfr_pkg::ST_CRCERR;
          crce_nxt   = crce_r + 16'd1;
        end else begin
          res_status   = cobs_dfr_pkg::ST_GOOD;
          good_len_nxt = 8'(dst_r - CW'(2));
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      ovf_r      <= 1'b0;
      good_len_r <= 8'h00;
      mal_r      <= 16'h0000;
      crce_r     <= 16'h0000;
      crc_init_r <= cobs_dfr_pkg::CRC_INIT_RESET;
    end else begin
      good_len_r <= good_len_nxt;
      mal_r      <= mal_nxt;
      crce_r     <= crce_nxt;
      if (cfg_we) begin
        crc_init_r <= cfg_data;
      end
      if (op == cobs_dfr_pkg::OP_ACCEPT) begin
        if (is_data) begin
          if (has_room) begin
            fill_r <= fill_r + CW'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end else if (is_delim) begin
          fill_r <= '0;
          if (fill_r != '0) begin
            ovf_r <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      cobs_dfr_pkg::OP_ACCEPT: begin
        rd_ok_r <= rd_ok;
        if (st.decode_needed) begin
          n_r       <= fill_r;
          src_r     <= '0;
          dst_r     <= '0;
          remain_r  <= 8'h00;
          code_ff_r <= 1'b1;
          crc_r     <= crc_init_r;
        end
      end
      cobs_dfr_pkg::OP_CODE: begin
        remain_r  <= rdata_r - 8'd1;
        code_ff_r <= rdata_r == cobs_dfr_pkg::CODE_FULL;
        src_r     <= src_r + CW'(1);
      end
      cobs_dfr_pkg::OP_BLK: begin
        if (st.zero_need) begin
          code_ff_r <= 1'b1;
        end
      end
      cobs_dfr_pkg::OP_DATA: begin
        src_r    <= src_r + CW'(1);
        remain_r <= remain_r - 8'd1;
      end
      default: begin
        rd_ok_r <= rd_ok_r;
      end
    endcase
    if (emit) begin
      dst_r <= dst_r + CW'(1);
      h0_r  <= emit_byte;
      h1_r  <= h0_r;
      if (dst_r >= CW'(2)) begin
        crc_r <= cobs_dfr_pkg::crc_byte(crc_r, h1_r);
      end
    end
    if (res_load) begin
      out_r.status          <= res_status;
      out_r.frame_length    <= good_len_nxt;
      out_r.read_data       <= ((op == cobs_dfr_pkg::OP_READ) && rd_ok_r) ? rdata_r : 8'h00;
      out_r.malformed_count <= mal_nxt;
      out_r.crc_error_count <= crce_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== src/cobs_deframer_crc16_check.sv =====
// A stored byte, an empty or overflowed delimiter: result in the cycle after the request.
// A store read: the memory read is registered, then the result is registered in S_RD.
// A frame delimiter walks the store in place, reading and writing it at once: each code byte
// uses S_CODE, S_BLK; a data byte S_DATA, S_BLK; an inserted zero S_BLK. One request at a time.
// Reset: counters, fill count, overflow flag and frame length clear; crc_init returns to 0xFFFF;
// the frame store is undefined until written.
`default_nettype none

module cobs_deframer_crc16_check #(
  parameter int CAPACITY = cobs_dfr_pkg::CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cobs_dfr_pkg::in_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cobs_dfr_pkg::out_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);

  cobs_dfr_pkg::dp_op_t op;
  cobs_dfr_pkg::dp_st_t st;

  assign cfg_ready = 1'b1;

  cobs_dfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .op        (op)
  );

  cobs_dfr_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .st       (st),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
